/* sv/qau_pkg.sv */
// Shared constants and types for the quaternion attitude update block.
`timescale 1ns / 1ps

package qau_pkg;

    localparam int QUAT_FRAC_BITS = 30;

    localparam int REG_W   = 31;
    localparam int RATE_W  = 32;
    localparam int ACCEL_W = 16;
    localparam int QUAT_W  = 32;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD   = 2'd2;

    localparam logic [REG_W-1:0] PROP_GAIN_RST     = 31'd26843546;
    localparam logic [REG_W-1:0] INTEGRAL_GAIN_RST = 31'd16777;
    localparam logic [REG_W-1:0] HALF_PERIOD_RST   = 31'd83886;

    localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(64'sd1 <<< QUAT_FRAC_BITS);

    // Command from the sequencer to the root/divide unit.
    typedef struct packed {
        logic start;
        logic root;
    } qau_cmd_t;

endpackage

/* sv/imu_quaternion_attitude_update.sv */
// Top level: IMU attitude update (complementary filter) with a shared multiplier sequencer.
`timescale 1ns / 1ps

// One sample in, one quaternion out. A sample with any zero accel count is
// answered in the next cycle with the stored quaternion and skipped set. Any other
// sample runs up to 65 sequencer steps on one shared 36x33 multiplier. Nine of those
// steps call a root/divide unit that resolves one bit per cycle while the
// sequencer waits. The block takes no new sample until the result has been
// transferred. Gains and half period are unsigned Q7.24; write them only while no
// sample is in flight.
module imu_quaternion_attitude_update (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [qau_pkg::RATE_W-1:0]      rate_x,
    input  logic signed [qau_pkg::RATE_W-1:0]      rate_y,
    input  logic signed [qau_pkg::RATE_W-1:0]      rate_z,
    input  logic signed [qau_pkg::ACCEL_W-1:0]     accel_x,
    input  logic signed [qau_pkg::ACCEL_W-1:0]     accel_y,
    input  logic signed [qau_pkg::ACCEL_W-1:0]     accel_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [qau_pkg::QUAT_W-1:0]      quat_w,
    output logic signed [qau_pkg::QUAT_W-1:0]      quat_x,
    output logic signed [qau_pkg::QUAT_W-1:0]      quat_y,
    output logic signed [qau_pkg::QUAT_W-1:0]      quat_z,
    output logic                                   skipped,
    input  logic                                   cfg_we,
    input  logic [qau_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [qau_pkg::REG_W-1:0]              cfg_data
);
    import qau_pkg::*;

    localparam int F = QUAT_FRAC_BITS;

    localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;
    localparam logic signed [63:0] SC_MIN   = -64'sd2147483647;
    localparam logic signed [63:0] ERR_LIM  = 64'sd1 <<< (F + 1);
    localparam logic signed [63:0] ERR_NLIM = -(64'sd1 <<< (F + 1));

    localparam logic [6:0] PC_ROOT_A = 7'd4;
    localparam logic [6:0] PC_DIV_U0 = 7'd5;
    localparam logic [6:0] PC_DIV_U1 = 7'd6;
    localparam logic [6:0] PC_DIV_U2 = 7'd7;
    localparam logic [6:0] PC_ROOT_N = 7'd60;
    localparam logic [6:0] PC_DIV_Q0 = 7'd61;
    localparam logic [6:0] PC_DIV_Q1 = 7'd62;
    localparam logic [6:0] PC_DIV_Q2 = 7'd63;
    localparam logic [6:0] PC_DIV_Q3 = 7'd64;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > S32_MAX)
            return 32'sh7FFF_FFFF;
        else if (x < S32_MIN)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] satc(input logic signed [63:0] x);
        if (x > S32_MAX)
            return 32'sh7FFF_FFFF;
        else if (x < SC_MIN)
            return 32'sh8000_0001;
        return x[31:0];
    endfunction

    function automatic logic signed [32:0] clamp_err(input logic signed [63:0] x);
        if (x > ERR_LIM)
            return ERR_LIM[32:0];
        else if (x < ERR_NLIM)
            return ERR_NLIM[32:0];
        return x[32:0];
    endfunction

    state_t state_reg, state_next;
    logic [6:0] pc_reg, pc_next;
    logic skipped_reg, skipped_next;

    logic [REG_W-1:0] kp_reg, kp_next;
    logic [REG_W-1:0] ki_reg, ki_next;
    logic [REG_W-1:0] hp_reg, hp_next;

    logic signed [31:0] q_reg [4];
    logic signed [31:0] q_next [4];
    logic signed [31:0] es_reg [3];
    logic signed [31:0] es_next [3];

    logic signed [31:0] rate_reg [3];
    logic signed [31:0] rate_next [3];
    logic signed [15:0] ac_reg [3];
    logic signed [15:0] ac_next [3];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];
    logic signed [35:0] v_reg [3];
    logic signed [35:0] v_next [3];
    logic signed [32:0] e_reg [3];
    logic signed [32:0] e_next [3];
    logic signed [31:0] g_reg [3];
    logic signed [31:0] g_next [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [31:0] n_reg [4];
    logic signed [31:0] n_next [4];
    logic [31:0] root_reg, root_next;
    logic signed [63:0] accum_reg, accum_next;
    logic signed [63:0] prod_reg, prod_next;

    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] mul_full;
    logic signed [63:0] p_fq;
    logic signed [63:0] p_fg;
    logic signed [63:0] p_hp;

    qau_cmd_t    unit_cmd;
    logic [63:0] unit_num;
    logic        unit_done;
    logic [31:0] unit_res;

    qau_divsqrt u_divsqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (unit_cmd),
        .num  (unit_num),
        .den  (root_reg),
        .done (unit_done),
        .res  (unit_res)
    );

    assign mul_full  = mul_a * mul_b;
    assign prod_next = mul_full[63:0];
    assign p_fq      = prod_reg >>> F;
    assign p_fg      = prod_reg >>> (F + 8);
    assign p_hp      = prod_reg >>> (40 - F);

    always_comb
    begin
        kp_next = kp_reg;
        ki_next = ki_reg;
        hp_next = hp_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     kp_next = cfg_data;
                REG_INTEGRAL_GAIN: ki_next = cfg_data;
                REG_HALF_PERIOD:   hp_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        skipped_next = skipped_reg;
        q_next       = q_reg;
        es_next      = es_reg;
        rate_next    = rate_reg;
        ac_next      = ac_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        e_next       = e_reg;
        g_next       = g_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        root_next    = root_reg;
        accum_next   = accum_reg;
        mul_a        = '0;
        mul_b        = '0;
        unit_cmd     = '0;
        unit_num     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rate_next[0] = rate_x;
                    rate_next[1] = rate_y;
                    rate_next[2] = rate_z;
                    ac_next[0]   = accel_x;
                    ac_next[1]   = accel_y;
                    ac_next[2]   = accel_z;
                    pc_next      = '0;
                    if (accel_x == '0 || accel_y == '0 || accel_z == '0)
                    begin
                        skipped_next = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        skipped_next = 1'b0;
                        state_next   = S_RUN;
                    end
                end
            end

            S_RUN:
            begin
                pc_next = pc_reg + 7'd1;
                // a step issues at most one product and may fold in the one from the step before
                unique case (pc_reg)
                    7'd0:  begin mul_a = 36'(ac_reg[0]); mul_b = 33'(ac_reg[0]); end
                    7'd1:  begin mul_a = 36'(ac_reg[1]); mul_b = 33'(ac_reg[1]);
                                 accum_next = prod_reg; end
                    7'd2:  begin mul_a = 36'(ac_reg[2]); mul_b = 33'(ac_reg[2]);
                                 accum_next = accum_reg + prod_reg; end
                    7'd3:  accum_next = accum_reg + prod_reg;
                    PC_ROOT_A, PC_DIV_U0, PC_DIV_U1, PC_DIV_U2:
                    begin
                        unit_cmd.start = 1'b1;
                        unit_cmd.root  = (pc_reg == PC_ROOT_A);
                        if (pc_reg == PC_ROOT_A)
                            unit_num = {accum_reg[31:0], 32'd0};
                        else if (pc_reg == PC_DIV_U0)
                            unit_num = 64'(ac_reg[0]) <<< (F + 16);
                        else if (pc_reg == PC_DIV_U1)
                            unit_num = 64'(ac_reg[1]) <<< (F + 16);
                        else
                            unit_num = 64'(ac_reg[2]) <<< (F + 16);
                        pc_next    = pc_reg;
                        state_next = S_WAIT;
                    end
                    // gravity direction from the stored quaternion
                    7'd8:  begin mul_a = 36'(q_reg[1]); mul_b = 33'(q_reg[3]); end
                    7'd9:  begin mul_a = 36'(q_reg[0]); mul_b = 33'(q_reg[2]);
                                 accum_next = p_fq; end
                    7'd10: begin mul_a = 36'(q_reg[0]); mul_b = 33'(q_reg[1]);
                                 accum_next = accum_reg - p_fq; end
                    7'd11: begin mul_a = 36'(q_reg[2]); mul_b = 33'(q_reg[3]);
                                 v_next[0] = {accum_reg[34:0], 1'b0};
                                 accum_next = p_fq; end
                    7'd12: begin mul_a = 36'(q_reg[0]); mul_b = 33'(q_reg[0]);
                                 accum_next = accum_reg + p_fq; end
                    7'd13: begin mul_a = 36'(q_reg[1]); mul_b = 33'(q_reg[1]);
                                 v_next[1] = {accum_reg[34:0], 1'b0};
                                 accum_next = p_fq; end
                    7'd14: begin mul_a = 36'(q_reg[2]); mul_b = 33'(q_reg[2]);
                                 accum_next = accum_reg - p_fq; end
                    7'd15: begin mul_a = 36'(q_reg[3]); mul_b = 33'(q_reg[3]);
                                 accum_next = accum_reg - p_fq; end
                    7'd16: accum_next = accum_reg + p_fq;
                    7'd17: v_next[2] = accum_reg[35:0];
                    // cross product error
                    7'd18: begin mul_a = v_reg[2]; mul_b = 33'(u_reg[1]); end
                    7'd19: begin mul_a = v_reg[1]; mul_b = 33'(u_reg[2]);
                                 accum_next = p_fq; end
                    7'd20: begin mul_a = v_reg[0]; mul_b = 33'(u_reg[2]);
                                 accum_next = accum_reg - p_fq; end
                    7'd21: begin mul_a = v_reg[2]; mul_b = 33'(u_reg[0]);
                                 e_next[0] = clamp_err(accum_reg);
                                 accum_next = p_fq; end
                    7'd22: begin mul_a = v_reg[1]; mul_b = 33'(u_reg[0]);
                                 accum_next = accum_reg - p_fq; end
                    7'd23: begin mul_a = v_reg[0]; mul_b = 33'(u_reg[1]);
                                 e_next[1] = clamp_err(accum_reg);
                                 accum_next = p_fq; end
                    7'd24: accum_next = accum_reg - p_fq;
                    7'd25: e_next[2] = clamp_err(accum_reg);
                    // integral terms
                    7'd26: begin mul_a = 36'(e_reg[0]); mul_b = 33'(ki_reg); end
                    7'd27: begin mul_a = 36'(e_reg[1]); mul_b = 33'(ki_reg);
                                 es_next[0] = sat32(64'(es_reg[0]) + p_fg); end
                    7'd28: begin mul_a = 36'(e_reg[2]); mul_b = 33'(ki_reg);
                                 es_next[1] = sat32(64'(es_reg[1]) + p_fg); end
                    7'd29: begin mul_a = 36'(e_reg[0]); mul_b = 33'(kp_reg);
                                 es_next[2] = sat32(64'(es_reg[2]) + p_fg); end
                    // corrected rates
                    7'd30: begin mul_a = 36'(e_reg[1]); mul_b = 33'(kp_reg);
                                 g_next[0] = sat32(64'(rate_reg[0]) + p_fg + 64'(es_reg[0])); end
                    7'd31: begin mul_a = 36'(e_reg[2]); mul_b = 33'(kp_reg);
                                 g_next[1] = sat32(64'(rate_reg[1]) + p_fg + 64'(es_reg[1])); end
                    7'd32: begin mul_a = 36'(g_reg[0]); mul_b = 33'(hp_reg);
                                 g_next[2] = sat32(64'(rate_reg[2]) + p_fg + 64'(es_reg[2])); end
                    // angle steps
                    7'd33: begin mul_a = 36'(g_reg[1]); mul_b = 33'(hp_reg);
                                 d_next[0] = sat32(p_hp); end
                    7'd34: begin mul_a = 36'(g_reg[2]); mul_b = 33'(hp_reg);
                                 d_next[1] = sat32(p_hp); end
                    7'd35: begin mul_a = 36'(q_reg[1]); mul_b = 33'(d_reg[0]);
                                 d_next[2] = sat32(p_hp); end
                    // integrate, each component using the ones already updated
                    7'd36: begin mul_a = 36'(q_reg[2]); mul_b = 33'(d_reg[1]);
                                 accum_next = 64'(q_reg[0]) - p_fq; end
                    7'd37: begin mul_a = 36'(q_reg[3]); mul_b = 33'(d_reg[2]);
                                 accum_next = accum_reg - p_fq; end
                    7'd38: accum_next = accum_reg - p_fq;
                    7'd39: n_next[0] = satc(accum_reg);
                    7'd40: begin mul_a = 36'(n_reg[0]); mul_b = 33'(d_reg[0]); end
                    7'd41: begin mul_a = 36'(q_reg[2]); mul_b = 33'(d_reg[2]);
                                 accum_next = 64'(q_reg[1]) + p_fq; end
                    7'd42: begin mul_a = 36'(q_reg[3]); mul_b = 33'(d_reg[1]);
                                 accum_next = accum_reg + p_fq; end
                    7'd43: accum_next = accum_reg - p_fq;
                    7'd44: n_next[1] = satc(accum_reg);
                    7'd45: begin mul_a = 36'(n_reg[0]); mul_b = 33'(d_reg[1]); end
                    7'd46: begin mul_a = 36'(n_reg[1]); mul_b = 33'(d_reg[2]);
                                 accum_next = 64'(q_reg[2]) + p_fq; end
                    7'd47: begin mul_a = 36'(q_reg[3]); mul_b = 33'(d_reg[0]);
                                 accum_next = accum_reg - p_fq; end
                    7'd48: accum_next = accum_reg + p_fq;
                    7'd49: n_next[2] = satc(accum_reg);
                    7'd50: begin mul_a = 36'(n_reg[0]); mul_b = 33'(d_reg[2]); end
                    7'd51: begin mul_a = 36'(n_reg[1]); mul_b = 33'(d_reg[1]);
                                 accum_next = 64'(q_reg[3]) + p_fq; end
                    7'd52: begin mul_a = 36'(n_reg[2]); mul_b = 33'(d_reg[0]);
                                 accum_next = accum_reg + p_fq; end
                    7'd53: accum_next = accum_reg - p_fq;
                    7'd54: n_next[3] = satc(accum_reg);
                    // norm squared, wraps as unsigned 64 bit
                    7'd55: begin mul_a = 36'(n_reg[0]); mul_b = 33'(n_reg[0]); end
                    7'd56: begin mul_a = 36'(n_reg[1]); mul_b = 33'(n_reg[1]);
                                 accum_next = prod_reg; end
                    7'd57: begin mul_a = 36'(n_reg[2]); mul_b = 33'(n_reg[2]);
                                 accum_next = accum_reg + prod_reg; end
                    7'd58: begin mul_a = 36'(n_reg[3]); mul_b = 33'(n_reg[3]);
                                 accum_next = accum_reg + prod_reg; end
                    7'd59: accum_next = accum_reg + prod_reg;
                    PC_ROOT_N:
                    begin
                        // zero norm: keep the stored quaternion
                        if (accum_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            unit_cmd.start = 1'b1;
                            unit_cmd.root  = 1'b1;
                            unit_num       = accum_reg;
                            pc_next        = pc_reg;
                            state_next     = S_WAIT;
                        end
                    end
                    PC_DIV_Q0, PC_DIV_Q1, PC_DIV_Q2, PC_DIV_Q3:
                    begin
                        unit_cmd.start = 1'b1;
                        unit_cmd.root  = 1'b0;
                        if (pc_reg == PC_DIV_Q0)
                            unit_num = 64'(n_reg[0]) <<< F;
                        else if (pc_reg == PC_DIV_Q1)
                            unit_num = 64'(n_reg[1]) <<< F;
                        else if (pc_reg == PC_DIV_Q2)
                            unit_num = 64'(n_reg[2]) <<< F;
                        else
                            unit_num = 64'(n_reg[3]) <<< F;
                        pc_next    = pc_reg;
                        state_next = S_WAIT;
                    end
                    default: ;
                endcase
            end

            S_WAIT:
            begin
                if (unit_done)
                begin
                    unique case (pc_reg)
                        PC_ROOT_A, PC_ROOT_N: root_next = unit_res;
                        PC_DIV_U0: u_next[0] = unit_res;
                        PC_DIV_U1: u_next[1] = unit_res;
                        PC_DIV_U2: u_next[2] = unit_res;
                        PC_DIV_Q0: q_next[0] = unit_res;
                        PC_DIV_Q1: q_next[1] = unit_res;
                        PC_DIV_Q2: q_next[2] = unit_res;
                        PC_DIV_Q3: q_next[3] = unit_res;
                        default: ;
                    endcase
                    pc_next    = pc_reg + 7'd1;
                    state_next = (pc_reg == PC_DIV_Q3) ? S_DONE : S_RUN;
                end
            end

            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            kp_reg    <= PROP_GAIN_RST;
            ki_reg    <= INTEGRAL_GAIN_RST;
            hp_reg    <= HALF_PERIOD_RST;
            q_reg[0]  <= QUAT_ONE;
            q_reg[1]  <= '0;
            q_reg[2]  <= '0;
            q_reg[3]  <= '0;
            es_reg[0] <= '0;
            es_reg[1] <= '0;
            es_reg[2] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            kp_reg    <= kp_next;
            ki_reg    <= ki_next;
            hp_reg    <= hp_next;
            q_reg     <= q_next;
            es_reg    <= es_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skipped_reg <= skipped_next;
        rate_reg    <= rate_next;
        ac_reg      <= ac_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        e_reg       <= e_next;
        g_reg       <= g_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        root_reg    <= root_next;
        accum_reg   <= accum_next;
        prod_reg    <= prod_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign quat_w    = q_reg[0];
    assign quat_x    = q_reg[1];
    assign quat_y    = q_reg[2];
    assign quat_z    = q_reg[3];
    assign skipped   = skipped_reg;

endmodule

/* sv/qau_divsqrt.sv */
// Iterative integer square root and signed-by-unsigned divide, one result bit per cycle.
`timescale 1ns / 1ps

module qau_divsqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  qau_pkg::qau_cmd_t   cmd,
    input  logic [63:0]         num,
    input  logic [31:0]         den,
    output logic                done,
    output logic [31:0]         res
);
    import qau_pkg::*;

    localparam logic [63:0] TOP_BIT = 64'h4000_0000_0000_0000;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mode_reg, mode_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;

    logic [63:0] bit_val;
    logic [64:0] trial_sum;
    logic [32:0] div_t;
    logic [32:0] div_d;
    logic [63:0] mag;

    always_comb
    begin
        bit_val   = TOP_BIT >> {cnt_reg, 1'b0};
        trial_sum = {1'b0, r_reg} + {1'b0, bit_val};
        div_t     = {r_reg[31:0], v_reg[31]};
        div_d     = div_t - {1'b0, den};
        mag       = num[63] ? (64'd0 - num) : num;

        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        r_next    = r_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            mode_next = cmd.root;
            cnt_next  = '0;
            if (cmd.root)
            begin
                v_next = num;
                r_next = '0;
            end
            else
            begin
                neg_next = num[63];
                r_next   = {32'd0, mag[63:32]};
                v_next   = {32'd0, mag[31:0]};
            end
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if ({1'b0, v_reg} >= trial_sum)
                begin
                    v_next = v_reg - trial_sum[63:0];
                    r_next = (r_reg >> 1) + bit_val;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
            end
            else
            begin
                // restoring step: shift in next numerator bit, subtract when it fits
                if (div_t >= {1'b0, den})
                begin
                    r_next = {32'd0, div_d[31:0]};
                    v_next = {32'd0, v_reg[30:0], 1'b1};
                end
                else
                begin
                    r_next = {32'd0, div_t[31:0]};
                    v_next = {32'd0, v_reg[30:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        neg_reg  <= neg_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
    end

    assign done = done_reg;
    assign res  = mode_reg ? r_reg[31:0] : (neg_reg ? (32'd0 - v_reg[31:0]) : v_reg[31:0]);

endmodule

/* sv/qau_check.sv */
// Port-level checker for the attitude update block, bound to the top level.
`timescale 1ns / 1ps

module qau_check (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic signed [qau_pkg::ACCEL_W-1:0]    accel_x,
    input logic signed [qau_pkg::ACCEL_W-1:0]    accel_y,
    input logic signed [qau_pkg::ACCEL_W-1:0]    accel_z,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [qau_pkg::QUAT_W-1:0]     quat_w,
    input logic                                  skipped
);
    import qau_pkg::*;

    // hold the result (quat_w and skipped) while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(skipped))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result waits");

    a_skip_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (accel_x == '0 || accel_y == '0 || accel_z == '0)
        |=> out_valid && skipped)
        else $error("skipped sample not answered at once");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && accel_x != '0 && accel_y != '0 && accel_z != '0
        |=> !out_valid && !in_ready)
        else $error("update sample not processed");

    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready && !out_valid)
        else $error("not ready after result transfer");

endmodule

bind imu_quaternion_attitude_update qau_check u_qau_check (.*);
